@@ sv/tlbpt_pkg.sv @@
// Package for the TLB page table translator.
// Holds the address geometry, the TLB and page table sizes, and the
// command and status structs between controller and datapath. No dependencies.
`timescale 1ns / 1ps

package tlbpt_pkg;

    localparam int ADDR_WIDTH    = 20;
    localparam int OFFSET_WIDTH  = 10;
    localparam int PAGE_WIDTH    = ADDR_WIDTH - OFFSET_WIDTH;
    localparam int FRAME_WIDTH   = PAGE_WIDTH;
    localparam int PAGE_COUNT    = 1 << PAGE_WIDTH;
    localparam int TLB_ENTRIES   = 16;
    localparam int TLB_IDX_WIDTH = $clog2(TLB_ENTRIES);
    localparam int FREE_WIDTH    = PAGE_WIDTH + 1;

    typedef logic [ADDR_WIDTH-1:0]    addr_t;
    typedef logic [PAGE_WIDTH-1:0]    page_t;
    typedef logic [FRAME_WIDTH-1:0]   frame_t;
    typedef logic [TLB_IDX_WIDTH-1:0] tlb_idx_t;

    // Page table word: valid flag above the frame number
    typedef struct packed {
        logic   valid;
        frame_t frame;
    } map_entry_t;

    typedef struct packed {
        logic  clear_wr;
        page_t clear_idx;
        logic  load;
        logic  commit;
    } tlbpt_cmd_t;

    typedef struct packed {
        logic out_stall;
    } tlbpt_sts_t;

endpackage

@@ sv/tlbpt_req_if.sv @@
// Request channel: one virtual address per transaction.
// Depends on tlbpt_pkg.
`timescale 1ns / 1ps

interface tlbpt_req_if;
    logic              valid;
    logic              ready;
    tlbpt_pkg::addr_t  virtual_address;

    modport source (output valid, output virtual_address, input ready);
    modport sink   (input valid, input virtual_address, output ready);
endinterface

@@ sv/tlbpt_rsp_if.sv @@
// Response channel: physical address with TLB hit and page fault flags.
// Depends on tlbpt_pkg.
`timescale 1ns / 1ps

interface tlbpt_rsp_if;
    logic              valid;
    logic              ready;
    tlbpt_pkg::addr_t  phys_addr;
    logic              tlb_hit;
    logic              page_fault;

    modport source (output valid, output phys_addr, output tlb_hit,
                    output page_fault, input ready);
    modport sink   (input valid, input phys_addr, input tlb_hit,
                    input page_fault, output ready);
endinterface

@@ sv/tlb_page_table_translator_core.sv @@
// Top level of the TLB page table translator.
// Depends on tlbpt_pkg, tlbpt_req_if, tlbpt_rsp_if, tlbpt_ctrl, tlbpt_datapath.
`timescale 1ns / 1ps

// Usage:
//   req carries one 20-bit virtual address per transaction: the upper 10 bits
//   are the page, the lower 10 bits the offset. rsp returns one transaction per
//   request: the physical address (frame above offset), tlb_hit and page_fault.
//   A TLB miss reads the page table; an unmapped page takes the next free
//   frame and the mapping is written to the page table. Every miss loads the
//   mapping into the 16-entry TLB, replacing entries in round-robin order.
// Timing:
//   An accepted request is registered together with its page table RAM read
//   and is looked up in the following cycle; its response enters the output
//   register when the lookup commits, and only then is a new request taken.
//   The lookup does the TLB compare, frame choice and RAM write-back.
// Reset:
//   After rst_n is released, the controller sweeps the page table RAM to clear
//   every valid flag, one page per cycle, over all 1024 pages; req.ready stays
//   low during the sweep. The TLB and frame allocator clear at once.
// Stalls:
//   The response sits in an output register. While it waits, one more request
//   is still accepted and looked up; that one holds until the register frees.
module tlb_page_table_translator_core (
    input  logic          clk,
    input  logic          rst_n,
    tlbpt_req_if.sink     req,
    tlbpt_rsp_if.source   rsp
);

    tlbpt_pkg::tlbpt_cmd_t cmd;
    tlbpt_pkg::tlbpt_sts_t sts;

    // sequence the clearing sweep, accept requests and commit lookups
    tlbpt_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (req.valid),
        .in_ready (req.ready),
        .sts      (sts),
        .cmd      (cmd)
    );

    // hold the TLB, page table and response register
    tlbpt_datapath u_datapath (
        .clk              (clk),
        .rst_n            (rst_n),
        .cmd              (cmd),
        .sts              (sts),
        .virtual_address  (req.virtual_address),
        .out_valid        (rsp.valid),
        .out_ready        (rsp.ready),
        .phys_addr        (rsp.phys_addr),
        .tlb_hit          (rsp.tlb_hit),
        .page_fault       (rsp.page_fault)
    );

endmodule

@@ sv/tlbpt_ctrl.sv @@
// Controller of the translator: page table clearing sweep, accept and commit.
// Depends on tlbpt_pkg.
`timescale 1ns / 1ps

module tlbpt_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  in_valid,
    output logic                  in_ready,
    input  tlbpt_pkg::tlbpt_sts_t sts,
    output tlbpt_pkg::tlbpt_cmd_t cmd
);

    typedef enum logic [1:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOOKUP
    } state_t;

    state_t             state_reg, state_next;
    tlbpt_pkg::page_t   clear_idx_reg, clear_idx_next;

    always_comb
    begin
        in_ready      = (state_reg == ST_IDLE);
        cmd.clear_wr  = (state_reg == ST_CLEAR);
        cmd.clear_idx = clear_idx_reg;
        cmd.load      = in_ready && in_valid;
        cmd.commit    = (state_reg == ST_LOOKUP) && !sts.out_stall;
    end

    always_comb
    begin
        state_next     = state_reg;
        clear_idx_next = clear_idx_reg;
        unique case (state_reg)
            ST_CLEAR:
            begin
                clear_idx_next = clear_idx_reg + tlbpt_pkg::PAGE_WIDTH'(1);
                if (clear_idx_reg == tlbpt_pkg::PAGE_WIDTH'(tlbpt_pkg::PAGE_COUNT - 1))
                    state_next = ST_IDLE;
            end
            ST_IDLE:
            begin
                if (cmd.load)
                    state_next = ST_LOOKUP;
            end
            ST_LOOKUP:
            begin
                // hold until the output register can take the result
                if (cmd.commit)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_CLEAR;
            clear_idx_reg <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            clear_idx_reg <= clear_idx_next;
        end
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.load |=> (state_reg == ST_LOOKUP))
        else $error("accepted transaction did not enter lookup");

    assert property (@(posedge clk) disable iff (!rst_n)
        !(cmd.clear_wr && (cmd.load || cmd.commit)))
        else $error("transaction handled during page table clearing");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |=> (state_reg == ST_IDLE))
        else $error("committed transaction did not return to idle");

endmodule

@@ sv/tlbpt_datapath.sv @@
// Datapath of the translator: TLB, page table RAM, frame allocator, output register.
// Depends on tlbpt_pkg.
`timescale 1ns / 1ps

module tlbpt_datapath (
    input  logic                  clk,
    input  logic                  rst_n,
    input  tlbpt_pkg::tlbpt_cmd_t cmd,
    output tlbpt_pkg::tlbpt_sts_t sts,
    input  tlbpt_pkg::addr_t      virtual_address,
    output logic                  out_valid,
    input  logic                  out_ready,
    output tlbpt_pkg::addr_t      phys_addr,
    output logic                  tlb_hit,
    output logic                  page_fault
);

    // page table RAM
    tlbpt_pkg::map_entry_t map_mem [tlbpt_pkg::PAGE_COUNT];
    tlbpt_pkg::map_entry_t map_rdata_reg;
    tlbpt_pkg::page_t      map_raddr;
    tlbpt_pkg::page_t      map_waddr;
    tlbpt_pkg::map_entry_t map_wdata;
    logic                  map_we;

    // TLB
    logic                  tlb_valid_reg [tlbpt_pkg::TLB_ENTRIES];
    tlbpt_pkg::page_t      tlb_page_reg  [tlbpt_pkg::TLB_ENTRIES];
    tlbpt_pkg::frame_t     tlb_frame_reg [tlbpt_pkg::TLB_ENTRIES];
    tlbpt_pkg::tlb_idx_t   replace_ptr_reg, replace_ptr_next;

    logic [tlbpt_pkg::FREE_WIDTH-1:0] next_free_reg, next_free_next;

    tlbpt_pkg::addr_t      va_reg;
    tlbpt_pkg::page_t      page_in;
    tlbpt_pkg::page_t      page_cur;
    logic [tlbpt_pkg::OFFSET_WIDTH-1:0] offset_cur;

    logic                  hit;
    logic                  fault;
    tlbpt_pkg::frame_t     hit_frame;
    tlbpt_pkg::frame_t     frame;

    logic                  out_valid_reg, out_valid_next;
    tlbpt_pkg::addr_t      pa_reg;
    logic                  hit_reg;
    logic                  fault_reg;

    assign page_in    = virtual_address[tlbpt_pkg::OFFSET_WIDTH +: tlbpt_pkg::PAGE_WIDTH];
    assign page_cur   = va_reg[tlbpt_pkg::OFFSET_WIDTH +: tlbpt_pkg::PAGE_WIDTH];
    assign offset_cur = va_reg[tlbpt_pkg::OFFSET_WIDTH-1:0];

    always_ff @(posedge clk)
    begin
        if (cmd.load)
            va_reg <= virtual_address;
    end

    // fully associative search; inserts happen only on a miss, so at most one match
    always_comb
    begin
        hit       = 1'b0;
        hit_frame = '0;
        for (int i = 0; i < tlbpt_pkg::TLB_ENTRIES; i++)
        begin
            if (tlb_valid_reg[i] && (tlb_page_reg[i] == page_cur))
            begin
                hit       = 1'b1;
                hit_frame = hit_frame | tlb_frame_reg[i];
            end
        end
    end

    always_comb
    begin
        fault = !hit && !map_rdata_reg.valid;
        if (hit)
            frame = hit_frame;
        else if (map_rdata_reg.valid)
            frame = map_rdata_reg.frame;
        else
            frame = next_free_reg[tlbpt_pkg::FRAME_WIDTH-1:0];
    end

    // RAM ports: read the incoming page on accept, re-read the held page otherwise
    always_comb
    begin
        map_raddr = cmd.load ? page_in : page_cur;
        map_we    = cmd.clear_wr || (cmd.commit && fault);
        if (cmd.clear_wr)
        begin
            map_waddr       = cmd.clear_idx;
            map_wdata.valid = 1'b0;
            map_wdata.frame = '0;
        end
        else
        begin
            map_waddr       = page_cur;
            map_wdata.valid = 1'b1;
            map_wdata.frame = frame;
        end
    end

    always_ff @(posedge clk)
    begin
        if (map_we)
            map_mem[map_waddr] <= map_wdata;
        map_rdata_reg <= map_mem[map_raddr];
    end

    always_comb
    begin
        replace_ptr_next = replace_ptr_reg;
        next_free_next   = next_free_reg;
        if (cmd.commit && !hit)
        begin
            if (replace_ptr_reg == tlbpt_pkg::TLB_IDX_WIDTH'(tlbpt_pkg::TLB_ENTRIES - 1))
                replace_ptr_next = '0;
            else
                replace_ptr_next = replace_ptr_reg + tlbpt_pkg::TLB_IDX_WIDTH'(1);
        end
        if (cmd.commit && fault
            && (next_free_reg < tlbpt_pkg::FREE_WIDTH'(tlbpt_pkg::PAGE_COUNT)))
            next_free_next = next_free_reg + tlbpt_pkg::FREE_WIDTH'(1);
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit && !hit)
        begin
            tlb_page_reg[replace_ptr_reg]  <= page_cur;
            tlb_frame_reg[replace_ptr_reg] <= frame;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < tlbpt_pkg::TLB_ENTRIES; i++)
                tlb_valid_reg[i] <= 1'b0;
            replace_ptr_reg <= '0;
            next_free_reg   <= '0;
        end
        else
        begin
            if (cmd.commit && !hit)
                tlb_valid_reg[replace_ptr_reg] <= 1'b1;
            replace_ptr_reg <= replace_ptr_next;
            next_free_reg   <= next_free_next;
        end
    end

    // output register
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (out_valid_reg && out_ready)
            out_valid_next = 1'b0;
        if (cmd.commit)
            out_valid_next = 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            out_valid_reg <= 1'b0;
        else
            out_valid_reg <= out_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            pa_reg    <= {frame, offset_cur};
            hit_reg   <= hit;
            fault_reg <= fault;
        end
    end

    assign sts.out_stall = out_valid_reg && !out_ready;
    assign out_valid     = out_valid_reg;
    assign phys_addr     = pa_reg;
    assign tlb_hit       = hit_reg;
    assign page_fault    = fault_reg;

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> !(hit_reg && fault_reg))
        else $error("result flagged as both TLB hit and page fault");

    assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.commit && fault
         && (next_free_reg < tlbpt_pkg::FREE_WIDTH'(tlbpt_pkg::PAGE_COUNT)))
        |=> (next_free_reg == $past(next_free_reg) + tlbpt_pkg::FREE_WIDTH'(1)))
        else $error("frame allocator did not advance on a page fault");

    assert property (@(posedge clk) disable iff (!rst_n)
        next_free_reg <= tlbpt_pkg::FREE_WIDTH'(tlbpt_pkg::PAGE_COUNT))
        else $error("frame allocator ran past the page count");

    assert property (@(posedge clk) disable iff (!rst_n)
        cmd.commit |-> !sts.out_stall)
        else $error("result committed over a stalled output register");

endmodule
